/* src/tss_pkg.sv */
// Shared types, constants and helpers of the truncation survivor selector.
`default_nettype none

package tss_pkg;

    localparam int DEF_MAX_POP     = 32;
    localparam int DEF_GENOME_BITS = 32;

    localparam int FIT_W  = 32;
    localparam int VAL_W  = 32;
    localparam int GEN_W  = 32;
    localparam int RANK_W = 5;
    localparam int POP_W  = 6;

    localparam logic [POP_W-1:0] POP_RESET = 6'd32;
    localparam logic [FIT_W-1:0] FIT_MIN   = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_REPLAY,
        ST_RD,
        ST_UPD,
        ST_SHOW
    } state_t;

    // Command broadcast to every cell of the insertion chain.
    typedef struct packed {
        logic ins;
        logic clr;
    } chain_cmd_t;

    // Signed greater-than on Q16.16 fitness patterns.
    function automatic logic fit_gt(input logic [FIT_W-1:0] a, input logic [FIT_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

`default_nettype wire

/* src/truncation_survivor_selector.sv */
// Loading takes one input beat per cycle. After the closing beat each survivor is read
// from the store (RD), the first also updates the best-ever pair (UPD), then shows (SHOW);
// each later one is read once the previous is taken. If pop_size shrank mid-generation the
// chain is rebuilt from the store first. Input is refused while a generation is emitted.
// Pace is set by the insertion chain (one compare per cell) and the single store read port.
// Reset clears control state, chain valid bits and the best-ever pair; no clearing pass.
`default_nettype none

module truncation_survivor_selector #(
    parameter int MAX_POP     = tss_pkg::DEF_MAX_POP,
    parameter int GENOME_BITS = tss_pkg::DEF_GENOME_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tss_pkg::POP_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [tss_pkg::FIT_W-1:0]  fitness,
    input  wire logic signed [tss_pkg::VAL_W-1:0]  value,
    input  wire logic [tss_pkg::GEN_W-1:0]         genome,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tss_pkg::RANK_W-1:0]             rank,
    output logic signed [tss_pkg::FIT_W-1:0]       fitness_out,
    output logic signed [tss_pkg::VAL_W-1:0]       value_out,
    output logic [tss_pkg::GEN_W-1:0]              genome_out,
    output logic signed [tss_pkg::FIT_W-1:0]       best_fitness,
    output logic signed [tss_pkg::VAL_W-1:0]       best_value,
    output logic                                   last
);

    localparam int DEPTH = 3 * MAX_POP;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(MAX_POP + 1);
    localparam int RW    = $clog2(MAX_POP);
    localparam int GW    = (GENOME_BITS < tss_pkg::GEN_W) ? GENOME_BITS : tss_pkg::GEN_W;

    tss_pkg::state_t state_reg;
    tss_pkg::state_t state_next;

    logic [tss_pkg::POP_W-1:0] pop_size_reg;
    logic [CW-1:0]             load_cnt_reg;
    logic [CW-1:0]             load_cnt_next;
    logic [CW-1:0]             total_reg;
    logic [CW-1:0]             total_next;
    logic [PW-1:0]             p_reg;
    logic [PW-1:0]             p_next;
    logic [CW-1:0]             rep_cnt_reg;
    logic [CW-1:0]             rep_cnt_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic [AW-1:0]             pend_idx_reg;
    logic [AW-1:0]             pend_idx_next;
    logic [RW-1:0]             rank_reg;
    logic [RW-1:0]             rank_next;
    logic [tss_pkg::FIT_W-1:0] best_fit_reg;
    logic [tss_pkg::FIT_W-1:0] best_fit_next;
    logic [tss_pkg::VAL_W-1:0] best_val_reg;
    logic [tss_pkg::VAL_W-1:0] best_val_next;

    logic [PW-1:0]             cur_p;
    logic [CW-1:0]             cur_total;
    logic [CW-1:0]             count_inc;
    logic                      in_beat;
    logic                      out_beat;
    logic                      close;
    logic                      replay_need;
    logic                      issue;
    logic                      is_last;

    tss_pkg::chain_cmd_t       cmd;
    logic [tss_pkg::FIT_W-1:0] x_fit;
    logic [AW-1:0]             x_idx;
    logic [AW-1:0]             sel_idx;

    logic                      mem_we;
    logic                      mem_re;
    logic [AW-1:0]             mem_raddr;
    logic [tss_pkg::FIT_W-1:0] rd_fit;
    logic [tss_pkg::VAL_W-1:0] rd_val;
    logic [GW-1:0]             rd_gen;

    // Clamp pop_size into 1..MAX_POP.
    always_comb
    begin
        if (pop_size_reg == '0)
        begin
            cur_p = PW'(1);
        end
        else if (32'(pop_size_reg) > MAX_POP)
        begin
            cur_p = PW'(MAX_POP);
        end
        else
        begin
            cur_p = PW'(pop_size_reg);
        end
    end

    assign cur_total   = CW'(cur_p) * CW'(3);
    assign count_inc   = load_cnt_reg + CW'(1);
    assign in_beat     = in_valid && in_ready;
    assign out_beat    = out_valid && out_ready;
    assign close       = in_beat && (count_inc >= cur_total);
    // entries loaded past the new total must not take part: rebuild the chain
    assign replay_need = (count_inc != cur_total);
    assign issue       = (rep_cnt_reg < total_reg);
    assign is_last     = ((PW'(rank_reg) + PW'(1)) == p_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tss_pkg::ST_LOAD:
            begin
                if (close)
                begin
                    state_next = replay_need ? tss_pkg::ST_REPLAY : tss_pkg::ST_RD;
                end
            end
            tss_pkg::ST_REPLAY:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = tss_pkg::ST_RD;
                end
            end
            tss_pkg::ST_RD:
            begin
                state_next = (rank_reg == '0) ? tss_pkg::ST_UPD : tss_pkg::ST_SHOW;
            end
            tss_pkg::ST_UPD:
            begin
                state_next = tss_pkg::ST_SHOW;
            end
            tss_pkg::ST_SHOW:
            begin
                if (out_beat)
                begin
                    state_next = is_last ? tss_pkg::ST_LOAD : tss_pkg::ST_RD;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        x_fit     = fitness;
        x_idx     = load_cnt_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = sel_idx;
        case (state_reg)
            tss_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.ins  = in_beat;
                cmd.clr  = close && replay_need;
                mem_we   = in_beat && (32'(load_cnt_reg) < DEPTH);
            end
            tss_pkg::ST_REPLAY:
            begin
                cmd.ins   = pend_reg;
                x_fit     = rd_fit;
                x_idx     = pend_idx_reg;
                mem_re    = issue;
                mem_raddr = rep_cnt_reg[AW-1:0];
            end
            tss_pkg::ST_RD:
            begin
                mem_re = 1'b1;
            end
            tss_pkg::ST_UPD:
            begin
                mem_re = 1'b0;
            end
            tss_pkg::ST_SHOW:
            begin
                out_valid = 1'b1;
                // empty the chain for the next generation
                cmd.clr   = out_beat && is_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Register updates
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        total_next    = total_reg;
        p_next        = p_reg;
        rep_cnt_next  = rep_cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        rank_next     = rank_reg;
        best_fit_next = best_fit_reg;
        best_val_next = best_val_reg;

        if (in_beat)
        begin
            load_cnt_next = close ? '0 : count_inc;
        end
        if (close)
        begin
            total_next   = cur_total;
            p_next       = cur_p;
            rep_cnt_next = '0;
            rank_next    = '0;
        end
        if (state_reg == tss_pkg::ST_REPLAY)
        begin
            pend_next     = issue;
            pend_idx_next = rep_cnt_reg[AW-1:0];
            if (issue)
            begin
                rep_cnt_next = rep_cnt_reg + CW'(1);
            end
        end
        if (state_reg == tss_pkg::ST_UPD && tss_pkg::fit_gt(rd_fit, best_fit_reg))
        begin
            best_fit_next = rd_fit;
            best_val_next = rd_val;
        end
        if (out_beat && !is_last)
        begin
            rank_next = rank_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tss_pkg::ST_LOAD;
            pop_size_reg <= tss_pkg::POP_RESET;
            load_cnt_reg <= '0;
            total_reg    <= '0;
            p_reg        <= '0;
            rep_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            rank_reg     <= '0;
            best_fit_reg <= tss_pkg::FIT_MIN;
            best_val_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            total_reg    <= total_next;
            p_reg        <= p_next;
            rep_cnt_reg  <= rep_cnt_next;
            pend_reg     <= pend_next;
            rank_reg     <= rank_next;
            best_fit_reg <= best_fit_next;
            best_val_reg <= best_val_next;
            if (cfg_valid && cfg_ready)
            begin
                pop_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
    end

    assign cfg_ready = 1'b1;

    tss_chain #(
        .MAX_POP (MAX_POP),
        .IDX_W   (AW),
        .SEL_W   (RW)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .x_fit   (x_fit),
        .x_idx   (x_idx),
        .sel     (rank_reg),
        .sel_idx (sel_idx)
    );

    tss_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .GW    (GW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wfit  (fitness),
        .wval  (value),
        .wgen  (genome[GW-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rfit  (rd_fit),
        .rval  (rd_val),
        .rgen  (rd_gen)
    );

    assign rank         = tss_pkg::RANK_W'(rank_reg);
    assign fitness_out  = rd_fit;
    assign value_out    = rd_val;
    assign genome_out   = tss_pkg::GEN_W'(rd_gen);
    assign best_fitness = best_fit_reg;
    assign best_value   = best_val_reg;
    assign last         = is_last;

`ifndef SYNTH
    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tss_pkg::ST_SHOW |-> PW'(rank_reg) < p_reg)
        else $error("survivor rank beyond population size");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("loading while emitting survivors");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        close |=> (load_cnt_reg == '0) && !in_ready)
        else $error("generation close did not reset the load count");

    a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready)
        else $error("load not reopened after last survivor");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tss_pkg::ST_UPD |=> !tss_pkg::fit_gt($past(best_fit_reg), best_fit_reg))
        else $error("best-ever fitness went down");
`endif

endmodule

`default_nettype wire

/* src/tss_cell.sv */
// One cell of the sorted insertion chain: holds a fitness and its load index.
`default_nettype none

module tss_cell #(
    parameter int IDX_W = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tss_pkg::chain_cmd_t         cmd,
    input  wire logic [tss_pkg::FIT_W-1:0]   x_fit,
    input  wire logic [IDX_W-1:0]            x_idx,
    input  wire logic                        prev_gt,
    input  wire logic                        prev_valid,
    input  wire logic [tss_pkg::FIT_W-1:0]   prev_fit,
    input  wire logic [IDX_W-1:0]            prev_idx,
    output logic                             gt,
    output logic                             valid,
    output logic [tss_pkg::FIT_W-1:0]        fit,
    output logic [IDX_W-1:0]                 idx
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [tss_pkg::FIT_W-1:0] fit_reg;
    logic [tss_pkg::FIT_W-1:0] fit_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;

    // Strictly greater only: an equal newcomer was loaded later and sorts below.
    assign gt = cmd.ins && (!valid_reg || tss_pkg::fit_gt(x_fit, fit_reg));

    always_comb
    begin
        valid_next = valid_reg;
        fit_next   = fit_reg;
        idx_next   = idx_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (prev_gt)
        begin
            // shift down from the neighbor above
            valid_next = prev_valid;
            fit_next   = prev_fit;
            idx_next   = prev_idx;
        end
        else if (gt)
        begin
            valid_next = 1'b1;
            fit_next   = x_fit;
            idx_next   = x_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fit_reg <= fit_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign fit   = fit_reg;
    assign idx   = idx_reg;

endmodule

`default_nettype wire

/* src/tss_chain.sv */
// Row of insertion cells keeping the fittest entries in descending order.
`default_nettype none

module tss_chain #(
    parameter int MAX_POP = tss_pkg::DEF_MAX_POP,
    parameter int IDX_W   = 7,
    parameter int SEL_W   = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tss_pkg::chain_cmd_t         cmd,
    input  wire logic [tss_pkg::FIT_W-1:0]   x_fit,
    input  wire logic [IDX_W-1:0]            x_idx,
    input  wire logic [SEL_W-1:0]            sel,
    output logic [IDX_W-1:0]                 sel_idx
);

    logic                      gt_c    [MAX_POP];
    logic                      valid_c [MAX_POP];
    logic [tss_pkg::FIT_W-1:0] fit_c   [MAX_POP];
    logic [IDX_W-1:0]          idx_c   [MAX_POP];

    genvar g;
    generate
        for (g = 0; g < MAX_POP; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                tss_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cmd        (cmd),
                    .x_fit      (x_fit),
                    .x_idx      (x_idx),
                    .prev_gt    (1'b0),
                    .prev_valid (1'b0),
                    .prev_fit   ('0),
                    .prev_idx   ('0),
                    .gt         (gt_c[g]),
                    .valid      (valid_c[g]),
                    .fit        (fit_c[g]),
                    .idx        (idx_c[g])
                );
            end
            else
            begin : g_body
                tss_cell #(.IDX_W(IDX_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cmd        (cmd),
                    .x_fit      (x_fit),
                    .x_idx      (x_idx),
                    .prev_gt    (gt_c[g-1]),
                    .prev_valid (valid_c[g-1]),
                    .prev_fit   (fit_c[g-1]),
                    .prev_idx   (idx_c[g-1]),
                    .gt         (gt_c[g]),
                    .valid      (valid_c[g]),
                    .fit        (fit_c[g]),
                    .idx        (idx_c[g])
                );
            end
        end
    endgenerate

    assign sel_idx = idx_c[sel];

endmodule

`default_nettype wire

/* src/tss_store.sv */
// Individual store: one write port, one registered read port.
`default_nettype none

module tss_store #(
    parameter int DEPTH = 96,
    parameter int AW    = 7,
    parameter int GW    = 32
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [tss_pkg::FIT_W-1:0]   wfit,
    input  wire logic [tss_pkg::VAL_W-1:0]   wval,
    input  wire logic [GW-1:0]               wgen,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic [tss_pkg::FIT_W-1:0]        rfit,
    output logic [tss_pkg::VAL_W-1:0]        rval,
    output logic [GW-1:0]                    rgen
);

    localparam int W = tss_pkg::FIT_W + tss_pkg::VAL_W + GW;

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wfit, wval, wgen};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rfit = rd_reg[W-1 -: tss_pkg::FIT_W];
    assign rval = rd_reg[GW +: tss_pkg::VAL_W];
    assign rgen = rd_reg[GW-1:0];

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking bench for the truncation survivor selector: directed and random generations.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_POP     = tss_pkg::DEF_MAX_POP;
    localparam int POOL_DEPTH  = 3 * MAX_POP;
    localparam int SETTLE      = 3 * MAX_POP + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [tss_pkg::RANK_W-1:0]       rank;
        logic signed [tss_pkg::FIT_W-1:0] fit;
        logic signed [tss_pkg::VAL_W-1:0] val;
        logic [tss_pkg::GEN_W-1:0]        gen;
        logic signed [tss_pkg::FIT_W-1:0] best_fit;
        logic signed [tss_pkg::VAL_W-1:0] best_val;
        logic                             last;
    } survivor_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [tss_pkg::POP_W-1:0]        cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [tss_pkg::FIT_W-1:0] fitness;
    logic signed [tss_pkg::VAL_W-1:0] value;
    logic [tss_pkg::GEN_W-1:0]        genome;
    logic                             out_valid;
    logic                             out_ready;
    logic [tss_pkg::RANK_W-1:0]       rank;
    logic signed [tss_pkg::FIT_W-1:0] fitness_out;
    logic signed [tss_pkg::VAL_W-1:0] value_out;
    logic [tss_pkg::GEN_W-1:0]        genome_out;
    logic signed [tss_pkg::FIT_W-1:0] best_fitness;
    logic signed [tss_pkg::VAL_W-1:0] best_value;
    logic                             last;

    // Mirror of the selector state
    logic [tss_pkg::POP_W-1:0]        pop_reg;
    logic signed [tss_pkg::FIT_W-1:0] pool_fit [POOL_DEPTH];
    logic signed [tss_pkg::VAL_W-1:0] pool_val [POOL_DEPTH];
    logic [tss_pkg::GEN_W-1:0]        pool_gen [POOL_DEPTH];
    int                               pool_count;
    logic signed [tss_pkg::FIT_W-1:0] kept_best_fit;
    logic signed [tss_pkg::VAL_W-1:0] kept_best_val;

    survivor_t               survivor_q [$];
    int                      generations_closed = 0;
    int                      items_sent = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;
    int                      in_idle_pct;
    int                      out_idle_pct;

    truncation_survivor_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .fitness      (fitness),
        .value        (value),
        .genome       (genome),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rank         (rank),
        .fitness_out  (fitness_out),
        .value_out    (value_out),
        .genome_out   (genome_out),
        .best_fitness (best_fitness),
        .best_value   (best_value),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Store one individual; on the closing beat rank the pool and queue the survivors.
    function automatic void load_individual(logic signed [tss_pkg::FIT_W-1:0] fit,
                                            logic signed [tss_pkg::VAL_W-1:0] val,
                                            logic [tss_pkg::GEN_W-1:0] gen);
        int        keep;
        int        total;
        int        top;
        int        r;
        int        i;
        int        j;
        survivor_t ranked [MAX_POP];
        keep = (pop_reg == 0) ? 1 : (pop_reg > MAX_POP) ? MAX_POP : int'(pop_reg);
        total = 3 * keep;
        if (pool_count < POOL_DEPTH)
        begin
            pool_fit[pool_count] = fit;
            pool_val[pool_count] = val;
            pool_gen[pool_count] = gen;
            pool_count++;
        end
        if (pool_count < total)
            return;
        top = 0;
        for (i = 1; i < total; i++)
            if (pool_fit[i] > pool_fit[top])
                top = i;
        if (pool_fit[top] > kept_best_fit)
        begin
            kept_best_fit = pool_fit[top];
            kept_best_val = pool_val[top];
        end
        for (i = 0; i < total; i++)
        begin
            r = 0;
            for (j = 0; j < total; j++)
                if (pool_fit[j] > pool_fit[i] || (j < i && pool_fit[j] == pool_fit[i]))
                    r++;
            if (r < keep)
            begin
                ranked[r].rank     = tss_pkg::RANK_W'(r);
                ranked[r].fit      = pool_fit[i];
                ranked[r].val      = pool_val[i];
                ranked[r].gen      = pool_gen[i];
                ranked[r].best_fit = kept_best_fit;
                ranked[r].best_val = kept_best_val;
                ranked[r].last     = (r == keep - 1);
            end
        end
        for (r = 0; r < keep; r++)
            survivor_q.push_back(ranked[r]);
        pool_count = 0;
        generations_closed++;
    endfunction

    function automatic logic [tss_pkg::FIT_W-1:0] pick_fitness();
        case ($urandom_range(3))
            0: return (tss_pkg::FIT_W'($urandom_range(4)) - 32'd2) << 16;   // crowd into ties
            1: return ($urandom_range(1) != 0) ? tss_pkg::FIT_MIN : 32'h7FFF_FFFF;
            default: return tss_pkg::FIT_W'($urandom);
        endcase
    endfunction

    task automatic send_individual(logic [tss_pkg::FIT_W-1:0] fit,
                                   logic [tss_pkg::VAL_W-1:0] val,
                                   logic [tss_pkg::GEN_W-1:0] gen);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        fitness  = fit;
        value    = val;
        genome   = gen;
        do
            @(posedge clk);
        while (!in_ready);
        load_individual(fit, val, gen);
        items_sent++;
    endtask

    // Write only with the selector idle: drop input, drain survivors, let the chain settle.
    task automatic write_pop_size(logic [tss_pkg::POP_W-1:0] n);
        @(negedge clk);
        in_valid = 1'b0;
        while (survivor_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = n;
        do
            @(posedge clk);
        while (!cfg_ready);
        pop_reg = n;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_ties_at_floor();
        // all fitness at the floor: equal to the kept best, so no update; load order wins
        write_pop_size(6'd1);
        send_individual(tss_pkg::FIT_MIN, 32'h0000_0001, 32'h0000_0000);
        send_individual(tss_pkg::FIT_MIN, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_individual(tss_pkg::FIT_MIN, 32'h8000_0000, 32'hA5A5_5A5A);
    endtask

    task automatic test_field_extremes();
        send_individual(32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_individual(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_individual(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
    endtask

    task automatic test_top_equal_to_best();
        // zero acts as one survivor
        write_pop_size(6'd0);
        send_individual(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000);
        send_individual(32'h7FFF_0000, 32'h0BAD_F00D, 32'h0000_FFFF);
        send_individual(32'h7FFF_FFFF, 32'hCAFE_0001, 32'hFFFF_0000);
    endtask

    task automatic test_rank_ties();
        write_pop_size(6'd2);
        send_individual(32'h0001_0000,     32'h0000_0010, 32'h0000_0001);
        send_individual(32'h0001_0000,     32'h0000_0020, 32'h0000_0002);
        send_individual(32'hFFFF_FFFF,     32'h0000_0030, 32'h0000_0003);
        send_individual(32'h0001_0000,     32'h0000_0040, 32'h0000_0004);
        send_individual(tss_pkg::FIT_MIN,  32'h0000_0050, 32'h0000_0005);
        send_individual(32'h0000_0000,     32'h0000_0060, 32'h0000_0006);
    endtask

    task automatic test_pop_change_mid_generation();
        write_pop_size(6'd4);
        repeat (5) send_individual(pick_fitness(), $urandom, $urandom);
        // shrink below the loaded count: the next beat closes the generation
        write_pop_size(6'd1);
        send_individual(pick_fitness(), $urandom, $urandom);
        repeat (2) send_individual(pick_fitness(), $urandom, $urandom);
        write_pop_size(6'd2);
        repeat (4) send_individual(pick_fitness(), $urandom, $urandom);
    endtask

    task automatic test_full_population();
        int closed_before;
        write_pop_size(6'd32);
        closed_before = generations_closed;
        repeat (7) send_individual(pick_fitness(), $urandom, $urandom);
        // above the maximum: acts as a full population
        write_pop_size(6'd63);
        while (generations_closed == closed_before)
            send_individual(pick_fitness(), $urandom, $urandom);
    endtask

    task automatic run_generations(int budget, int pop_lo, int pop_hi, bit mid_change);
        int start_items;
        int closed_before;
        start_items = items_sent;
        while (items_sent - start_items < budget)
        begin
            write_pop_size(tss_pkg::POP_W'($urandom_range(pop_lo, pop_hi)));
            closed_before = generations_closed;
            if (mid_change && $urandom_range(2) == 0)
            begin
                repeat ($urandom_range(1, 5)) send_individual(pick_fitness(), $urandom, $urandom);
                write_pop_size(($urandom_range(3) == 0) ? tss_pkg::POP_W'(0)
                                                        : tss_pkg::POP_W'($urandom_range(1, 6)));
            end
            while (generations_closed == closed_before)
                send_individual(pick_fitness(), $urandom, $urandom);
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        survivor_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (survivor_q.size() == 0)
                report_mismatch("survivor with nothing pending, fitness", fitness_out, 32'h0);
            else
            begin
                want = survivor_q.pop_front();
                if (rank !== want.rank)
                    report_mismatch("rank", rank, want.rank);
                if (fitness_out !== want.fit)
                    report_mismatch("fitness_out", fitness_out, want.fit);
                if (value_out !== want.val)
                    report_mismatch("value_out", value_out, want.val);
                if (genome_out !== want.gen)
                    report_mismatch("genome_out", genome_out, want.gen);
                if (best_fitness !== want.best_fit)
                    report_mismatch("best_fitness", best_fitness, want.best_fit);
                if (best_value !== want.best_val)
                    report_mismatch("best_value", best_value, want.best_val);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        fitness       = '0;
        value         = '0;
        genome        = '0;
        in_idle_pct   = 28;
        out_idle_pct  = 74;
        pop_reg       = tss_pkg::POP_RESET;
        pool_count    = 0;
        kept_best_fit = tss_pkg::FIT_MIN;
        kept_best_val = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ties_at_floor();
        test_field_extremes();
        test_top_equal_to_best();
        test_rank_ties();
        test_pop_change_mid_generation();
        test_full_population();

        in_idle_pct  = 74;
        out_idle_pct = 28;
        run_generations(60, 2, 8, 1'b0);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_generations(50, 2, 6, 1'b1);

        @(negedge clk);
        in_valid = 1'b0;
        while (survivor_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
